// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the trigger
`define CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition holds in the cycle after the trigger
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bbs_pkg.sv =====
// Package for the balanced brace scanner: lexical mode codes, character
// constants and the result record passed from the lexer to the top level.
package bbs_pkg;

	// lexical modes
	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_STRING = 3'd1;
	localparam logic [2:0] MODE_CHAR   = 3'd2;
	localparam logic [2:0] MODE_LINE   = 3'd3;
	localparam logic [2:0] MODE_BLOCK  = 3'd4;

	// characters of interest
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// result of one byte
	typedef struct packed {
		logic       active;
		logic [7:0] depth;
		logic [2:0] mode;
		logic       match;
		logic       unmatched;
		logic       overflow;
	} scan_result_t;

endpackage

// ===== src/bbs_lexer.sv =====
// Lexer state and next-state logic of the brace scanner: mode, escape and
// comment-marker flags and the nesting counter. Depends on bbs_pkg.
module bbs_lexer import bbs_pkg::*; #(
	parameter int MAX_DEPTH = 255
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  logic [7:0]   text_byte,
	input  logic         start_scan,
	output scan_result_t result
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_TOP = DW'(MAX_DEPTH);
	localparam logic [DW-1:0] DEPTH_ONE = DW'(1);

	logic          run_q, run_d;
	logic [DW-1:0] lvl_q, lvl_d;
	logic [2:0]    mode_q, mode_d;
	logic          slash_q, slash_d;
	logic          star_q, star_d;
	logic          esc_q, esc_d;

	logic          taken;
	logic          hit_match, hit_end, hit_ovf;
	logic [DW-1:0] lvl_dec;
	logic [7:0]    quote;
	logic [DW+7:0] ext_now, ext_next;

	// work out the state after this byte and its result
	always_comb begin
		run_d     = run_q;
		lvl_d     = lvl_q;
		mode_d    = mode_q;
		slash_d   = slash_q;
		star_d    = star_q;
		esc_d     = esc_q;
		taken     = 1'b0;
		hit_match = 1'b0;
		hit_end   = 1'b0;
		hit_ovf   = 1'b0;
		lvl_dec   = (lvl_q != '0) ? lvl_q - DEPTH_ONE : lvl_q;
		quote     = (mode_q == MODE_STRING) ? CH_DQUOTE : CH_SQUOTE;

		if (start_scan) begin
			run_d   = 1'b1;
			lvl_d   = DEPTH_ONE;
			mode_d  = MODE_NORMAL;
			slash_d = 1'b0;
			star_d  = 1'b0;
			esc_d   = 1'b0;
		end else if (run_q) begin
			if (text_byte == CH_NUL) begin
				// text ended before the match
				hit_end = 1'b1;
				run_d   = 1'b0;
				lvl_d   = '0;
				mode_d  = MODE_NORMAL;
				slash_d = 1'b0;
				star_d  = 1'b0;
				esc_d   = 1'b0;
			end else begin
				unique case (mode_q)
					MODE_STRING, MODE_CHAR: begin
						if (esc_q) begin
							esc_d = 1'b0;
						end else if (text_byte == CH_BSLASH) begin
							esc_d = 1'b1;
						end else if (text_byte == quote) begin
							mode_d = MODE_NORMAL;
						end
					end
					MODE_LINE: begin
						if (text_byte == CH_NL) begin
							mode_d = MODE_NORMAL;
						end
					end
					MODE_BLOCK: begin
						if (star_q && text_byte == CH_SLASH) begin
							star_d = 1'b0;
							mode_d = MODE_NORMAL;
						end else begin
							star_d = (text_byte == CH_STAR);
						end
					end
					default: begin
						// second byte of a comment marker
						if (slash_q) begin
							slash_d = 1'b0;
							if (text_byte == CH_SLASH) begin
								mode_d = MODE_LINE;
								taken  = 1'b1;
							end else if (text_byte == CH_STAR) begin
								mode_d = MODE_BLOCK;
								star_d = 1'b0;
								taken  = 1'b1;
							end
						end
						if (!taken) begin
							mode_d = MODE_NORMAL;
							if (text_byte == CH_SLASH) begin
								slash_d = 1'b1;
							end else if (text_byte == CH_DQUOTE) begin
								mode_d = MODE_STRING;
								esc_d  = 1'b0;
							end else if (text_byte == CH_SQUOTE) begin
								mode_d = MODE_CHAR;
								esc_d  = 1'b0;
							end else if (text_byte == CH_LBRACE) begin
								if (lvl_q >= DEPTH_TOP) begin
									hit_ovf = 1'b1;
								end else begin
									lvl_d = lvl_q + DEPTH_ONE;
								end
							end else if (text_byte == CH_RBRACE) begin
								lvl_d = lvl_dec;
								if (lvl_dec == '0) begin
									// closing brace of the scan
									hit_match = 1'b1;
									run_d     = 1'b0;
									mode_d    = MODE_NORMAL;
									slash_d   = 1'b0;
									star_d    = 1'b0;
									esc_d     = 1'b0;
								end
							end
						end
					end
				endcase
			end
		end

		// assemble the result
		ext_now          = {8'b0, lvl_q};
		ext_next         = {8'b0, lvl_d};
		result           = '0;
		result.match     = hit_match;
		result.unmatched = hit_end;
		result.overflow  = hit_ovf;
		if (run_d) begin
			result.active = 1'b1;
			result.depth  = ext_next[7:0];
			result.mode   = mode_d;
		end else if (hit_end) begin
			result.depth = ext_now[7:0];
			result.mode  = mode_q;
		end
	end

	// hold state, advance on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			lvl_q   <= '0;
			mode_q  <= MODE_NORMAL;
			slash_q <= 1'b0;
			star_q  <= 1'b0;
			esc_q   <= 1'b0;
		end else if (advance) begin
			run_q   <= run_d;
			lvl_q   <= lvl_d;
			mode_q  <= mode_d;
			slash_q <= slash_d;
			star_q  <= star_d;
			esc_q   <= esc_d;
		end
	end

endmodule

// ===== src/balanced_brace_scanner_top.sv =====
// Balanced brace scanner, top level: byte channel in, result register out.
// The result of an accepted byte is registered and shows on the output in the next cycle.
// Throughput: one byte per cycle while the byte channel is not stalled.
// The byte channel stalls only while a held result is itself stalled.
// Reset (arst_n low) clears the lexer state and the result valid at once.
module balanced_brace_scanner_top import bbs_pkg::*; #(
	parameter int MAX_DEPTH = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       start_scan,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       scan_active,
	output logic [7:0] brace_depth,
	output logic [2:0] lex_mode,
	output logic       match_found,
	output logic       unmatched,
	output logic       depth_overflow
);

	logic         accept;
	logic         res_valid_q;
	scan_result_t res_next;
	scan_result_t res_q;

	// take a transaction unless a held result is blocked downstream
	assign text_stall = res_valid_q && result_stall;
	assign accept     = text_valid && !text_stall;

	bbs_lexer #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.text_byte (text_byte),
		.start_scan(start_scan),
		.result    (res_next)
	);

	// result valid: set on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_next;
		end
	end

	assign result_valid   = res_valid_q;
	assign scan_active    = res_q.active;
	assign brace_depth    = res_q.depth;
	assign lex_mode       = res_q.mode;
	assign match_found    = res_q.match;
	assign unmatched      = res_q.unmatched;
	assign depth_overflow = res_q.overflow;

endmodule

// ===== src/bbs_checker.sv =====
// Port-level checker for the balanced brace scanner, bound to its top level.
// Depends on bbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bbs_checker import bbs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic       scan_active,
	input logic [7:0] brace_depth,
	input logic [2:0] lex_mode,
	input logic       match_found,
	input logic       unmatched,
	input logic       depth_overflow
);

	// a stalled result transaction holds
	`CHK_NEXT(a_res_hold, result_valid && result_stall,
		result_valid && $stable(scan_active) && $stable(brace_depth)
			&& $stable(lex_mode) && $stable(match_found)
			&& $stable(unmatched) && $stable(depth_overflow),
		"stalled result changed")

	// a match closes the scan at depth zero in normal mode
	`CHK_SAME(a_match_close, result_valid && match_found,
		!scan_active && !unmatched && brace_depth == 8'd0 && lex_mode == MODE_NORMAL,
		"match result malformed")

	// end of text closes the scan
	`CHK_SAME(a_end_close, result_valid && unmatched,
		!scan_active && !match_found && !depth_overflow,
		"unmatched result malformed")

	// an overflow only comes from a brace in normal mode of a live scan
	`CHK_SAME(a_ovf_live, result_valid && depth_overflow,
		scan_active && lex_mode == MODE_NORMAL,
		"overflow outside a live scan")

	// an idle result carries nothing
	`CHK_SAME(a_idle_zero, result_valid && !scan_active && !unmatched,
		brace_depth == 8'd0 && lex_mode == MODE_NORMAL,
		"idle result not clear")

endmodule

bind balanced_brace_scanner_top bbs_checker u_bbs_checker (.*);
